### rtl/gb5_pkg.sv
// Shared constants, types and kernel weights for the 5x5 Gaussian blur.
package gb5_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 12;
   localparam int PIX_W      = 8;
   localparam int WGT_W      = 4;
   localparam int CSUM_W     = 14;
   localparam int SUM_W      = 16;
   localparam int POS_W      = 11;
   localparam int MIN_DIM    = 5;

   // floor(x / 159) == (x * 52759) >> 23 for every x up to 159 * 255
   localparam int RECIP_W     = 16;
   localparam int RECIP_MUL   = 52759;
   localparam int RECIP_SHIFT = 23;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [4:0][PIX_W-1:0] pix_col_type;
   typedef logic [4:0][WGT_W-1:0] wgt_col_type;

   localparam wgt_col_type KERN_EDGE = {4'd2, 4'd4, 4'd5, 4'd4, 4'd2};
   localparam wgt_col_type KERN_NEAR = {4'd4, 4'd9, 4'd12, 4'd9, 4'd4};
   localparam wgt_col_type KERN_MID  = {4'd5, 4'd12, 4'd15, 4'd12, 4'd5};

   function automatic wgt_col_type kern_col(input logic [2:0] col);
      wgt_col_type w;
      case (col)
         3'd0, 3'd4: w = KERN_EDGE;
         3'd1, 3'd3: w = KERN_NEAR;
         3'd2:       w = KERN_MID;
         default:    w = KERN_EDGE;
      endcase
      return w;
   endfunction

endpackage

### rtl/gb5_line_ram.sv
// One line store: a row of pixels, read-before-write at a shared address.
module gb5_line_ram (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic                                    wr_en,
   input  logic [gb5_pkg::COL_W-1:0]               addr,
   input  logic [gb5_pkg::PIX_W-1:0]               wr_data,
   output logic [gb5_pkg::PIX_W-1:0]               rd_data
);

   logic [gb5_pkg::PIX_W-1:0] mem_ff [gb5_pkg::MAX_WIDTH];
   logic [gb5_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // old contents come out: the slot being written holds the row four above
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gb5_col_cell.sv
// One window column: five pixels that move one cell left per beat, and their weighted sum.
module gb5_col_cell (
   input  logic                                    clock,
   input  logic                                    shift_en,
   input  gb5_pkg::pix_col_type                    col_in,
   input  gb5_pkg::wgt_col_type                    weights,
   output gb5_pkg::pix_col_type                    col_out,
   output logic [gb5_pkg::CSUM_W-1:0]              col_sum
);

   gb5_pkg::pix_col_type col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      logic [gb5_pkg::CSUM_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 5; k++) begin
         acc = acc + gb5_pkg::CSUM_W'(col_ff[k]) * gb5_pkg::CSUM_W'(weights[k]);
      end
      col_sum = acc;
   end

   assign col_out = col_ff;

endmodule

### rtl/gaussian_blur_5x5_top.sv
// Top level of the 5x5 Gaussian blur: position counters, line stores, window and divide.
// Takes one pixel per clock in raster order while no result is held back and gives the
// 5x5 Gaussian blur (weights 2,4,5,4,2 / 4,9,12,9,4 / 5,12,15,12,5 / 4,9,12,9,4 /
// 2,4,5,4,2, divided by 159, truncated) for every pixel at least two away from each
// border; border pixels give nothing. Once pixel (r+2,c+2) is taken, the result for
// centre (r,c) passes through stage 1, the window with stage 2, stage 3 and the output
// register, with rsp_tlast on the last interior pixel of the frame. Throughput is one
// pixel per clock when not stalled, set by the four line stores: each is a separate RAM
// that is read and written once per clock at the current column. The stores need no
// clearing after reset; the first four rows of a frame only fill them. req_tuser starts
// a frame at pixel (0,0); without it the frame wraps after image_height rows. Width and
// height are clamped to 5..2048 and should be changed only while no pixel is in flight.
module gaussian_blur_5x5_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] pixel_in
   input  logic         req_tuser,   // frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [7:0] blurred_pixel, [18:8] center_row,
                                     // [29:19] center_col, [31:30] zero
   output logic         rsp_tlast,   // frame_last
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [11:0]  csr_data
);

   localparam int COL_W = gb5_pkg::COL_W;
   localparam int ROW_W = gb5_pkg::ROW_W;
   localparam int DIM_W = gb5_pkg::DIM_W;
   localparam int PIX_W = gb5_pkg::PIX_W;
   localparam int POS_W = gb5_pkg::POS_W;
   localparam int SUM_W = gb5_pkg::SUM_W;
   localparam int PROD_W = SUM_W + gb5_pkg::RECIP_W;

   // configuration
   logic [DIM_W-1:0] image_width_ff, image_height_ff;
   logic [DIM_W-1:0] w_eff, h_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_W'(1024);
         image_height_ff <= DIM_W'(1024);
      end else if (csr_valid) begin
         case (csr_index)
            gb5_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            gb5_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (image_width_ff < DIM_W'(gb5_pkg::MIN_DIM)) begin
         w_eff = DIM_W'(gb5_pkg::MIN_DIM);
      end else if (image_width_ff > DIM_W'(gb5_pkg::MAX_WIDTH)) begin
         w_eff = DIM_W'(gb5_pkg::MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      if (image_height_ff < DIM_W'(gb5_pkg::MIN_DIM)) begin
         h_eff = DIM_W'(gb5_pkg::MIN_DIM);
      end else if (image_height_ff > DIM_W'(gb5_pkg::MAX_HEIGHT)) begin
         h_eff = DIM_W'(gb5_pkg::MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   // pipeline advance: everything moves unless a result is waiting and rsp_tready is low
   logic en;
   logic accept;
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // position of the incoming pixel
   logic [COL_W-1:0] col_ff, col_in, c0;
   logic [ROW_W-1:0] row_ff, row_in, r0;
   logic             emit0, last0, col_end, row_end;

   assign r0 = req_tuser ? '0 : row_ff;
   assign c0 = req_tuser ? '0 : col_ff;

   always_comb begin
      emit0   = (r0 >= ROW_W'(4)) && (c0 >= COL_W'(4)) &&
                (DIM_W'(r0) < h_eff) && (DIM_W'(c0) < w_eff);
      last0   = (DIM_W'(r0) == h_eff - DIM_W'(1)) && (DIM_W'(c0) == w_eff - DIM_W'(1));
      col_end = DIM_W'(c0) >= w_eff - DIM_W'(1);
      row_end = DIM_W'(r0) >= h_eff - DIM_W'(1);
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : r0 + ROW_W'(1);
      end else begin
         col_in = c0 + COL_W'(1);
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores, one per row slot (row mod 4)
   logic [3:0][PIX_W-1:0] rd_data;

   for (genvar m = 0; m < 4; m++) begin : g_line
      gb5_line_ram u_line (
         .clock   (clock),
         .rd_en   (accept),
         .wr_en   (accept && (r0[1:0] == 2'(m))),
         .addr    (c0),
         .wr_data (req_tdata),
         .rd_data (rd_data[m])
      );
   end

   // stage 1: store data arrives
   logic             s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [1:0]       s1_slot_ff;
   logic [PIX_W-1:0] s1_px_ff;
   logic [POS_W-1:0] s1_row_ff, s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_emit_ff <= emit0;
         s1_last_ff <= last0;
         s1_slot_ff <= r0[1:0];
         s1_px_ff   <= req_tdata;
         s1_row_ff  <= POS_W'(r0 - ROW_W'(2));
         s1_col_ff  <= POS_W'(c0 - COL_W'(2));
      end
   end

   // window: chain of five column cells, newest column enters at cell 4
   gb5_pkg::pix_col_type new_col;
   gb5_pkg::pix_col_type [4:0] cell_col;
   logic [4:0][gb5_pkg::CSUM_W-1:0] cell_sum;
   logic shift_en;

   assign shift_en = en && s1_valid_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         new_col[k] = rd_data[2'(s1_slot_ff + 2'(k))];
      end
      new_col[4] = s1_px_ff;
   end

   for (genvar j = 0; j < 5; j++) begin : g_cell
      gb5_col_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .col_in   ((j == 4) ? new_col : cell_col[(j + 1) % 5]),
         .weights  (gb5_pkg::kern_col(3'(j))),
         .col_out  (cell_col[j]),
         .col_sum  (cell_sum[j])
      );
   end

   // stage 2: window holds this pixel's neighbourhood
   logic             s2_emit_ff, s2_last_ff;
   logic [POS_W-1:0] s2_row_ff, s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else if (en) begin
         s2_emit_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_last_ff <= s1_last_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
      end
   end

   // stage 3: total weighted sum
   logic             s3_emit_ff, s3_last_ff;
   logic [POS_W-1:0] s3_row_ff, s3_col_ff;
   logic [SUM_W-1:0] s3_sum_ff, sum_in;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < 5; j++) begin
         sum_in = sum_in + SUM_W'(cell_sum[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_emit_ff <= 1'b0;
      end else if (en) begin
         s3_emit_ff <= s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_last_ff <= s2_last_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_sum_ff  <= sum_in;
      end
   end

   // output register: divide by 159 through the reciprocal
   logic [PROD_W-1:0] prod;
   logic [31:0]       rsp_tdata_ff, rsp_tdata_in;
   logic              rsp_tlast_ff;

   assign prod = PROD_W'(s3_sum_ff) * PROD_W'(gb5_pkg::RECIP_MUL);
   assign rsp_tdata_in = {2'b00, s3_col_ff, s3_row_ff, prod[gb5_pkg::RECIP_SHIFT +: PIX_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // a frame start puts the next pixel at row 0, column 1 whatever the size
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> (col_ff == COL_W'(1)) && (row_ff == '0))
      else $error("counters wrong after frame start");

   // results only come from interior pixels
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:8] >= POS_W'(2)) && (rsp_tdata[29:19] >= POS_W'(2)))
      else $error("result for a border pixel");

   // a stall freezes the sum stage
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s3_sum_ff) && $stable(s3_emit_ff))
      else $error("sum stage moved during a stall");

   // the window moves only for an accepted pixel, possibly held over a stall
   a_shift_src: assert property (@(posedge clock) disable iff (reset)
      shift_en |-> $past(accept) || !$past(en))
      else $error("window shifted without a pixel");

endmodule
